### hdl/vf_ramp_angle_generator_unit_assert.svh
// assertion macros for the v/f ramp and angle generator
// no dependencies; included by the top level only
`ifndef VF_RAMP_ANGLE_GENERATOR_UNIT_ASSERT_SVH
`define VF_RAMP_ANGLE_GENERATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define VFRAG_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vfrag assertion failed");
`define VFRAG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vfrag assertion failed");
`else
`define VFRAG_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define VFRAG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hdl/vfrag_pkg.sv
// shared types, constants and helper functions for the v/f ramp and angle generator
// no dependencies
`timescale 1ns / 1ps

package vfrag_pkg;

    localparam int unsigned ANGLE_FULL_SCALE_DEF = 65536;

    localparam int ANGLE_W   = 17;
    localparam int VOLT_W    = 15;
    localparam int SPEED_W   = 16;
    localparam int VPH_W     = 8;
    localparam int RAMP_W    = 10;
    localparam int INCR_W    = 16;
    localparam int OUT_W     = ANGLE_W + VOLT_W + SPEED_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int PROD_W    = 2 * INCR_W;
    localparam int DIV_STEPS = INCR_W;
    localparam int CNT_W     = 4;

    localparam logic [VOLT_W-1:0]    VOLT_LIMIT = 15'd32000;
    localparam logic [INCR_W-1:0]    INCR_MAX   = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_VOLTS_PER_HZ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_DIVISOR = 2'd3;

    localparam logic [VPH_W-1:0]   VOLTS_PER_HZ_RST  = 8'd25;
    localparam logic [RAMP_W-1:0]  RAMP_STEP_RST     = 10'd3;
    localparam logic [INCR_W-1:0]  ANGLE_STEP_RST    = 16'd707;
    localparam logic [SPEED_W-1:0] SPEED_DIVISOR_RST = 16'd2025;

    typedef struct packed {
        logic [VPH_W-1:0]   volts_per_hz;
        logic [RAMP_W-1:0]  ramp_step;
        logic [INCR_W-1:0]  angle_step_max;
        logic [SPEED_W-1:0] full_speed_divisor;
    } cfg_t;

    typedef struct packed {
        logic load_ref;
        logic volt;
        logic mul;
        logic incr_sat;
        logic div_init;
        logic div_step;
        logic tadd;
        logic mod_init;
        logic mod_step;
        logic acc_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_sat;
        logic wrap;
        logic last;
    } status_t;

    // largest shift of the full scale that the wrap reduction starts from
    function automatic int mod_shift(input longint fs);
        int s;
        s = 0;
        for (int i = 0; i < 32; i++) begin
            if ((fs << (s + 1)) <= (fs + longint'(INCR_MAX) - 1)) begin
                s = s + 1;
            end
        end
        return s;
    endfunction

endpackage

### hdl/vfrag_cfg.sv
// configuration register bank for the v/f ramp and angle generator
// depends on vfrag_pkg
`timescale 1ns / 1ps

module vfrag_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [vfrag_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [vfrag_pkg::CFG_DAT_W-1:0]     wr_data,
    output vfrag_pkg::cfg_t                     cfg
);

    vfrag_pkg::cfg_t cfg_reg;
    vfrag_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                vfrag_pkg::REG_VOLTS_PER_HZ:
                    cfg_next.volts_per_hz = wr_data[vfrag_pkg::VPH_W-1:0];
                vfrag_pkg::REG_RAMP_STEP:
                    cfg_next.ramp_step = wr_data[vfrag_pkg::RAMP_W-1:0];
                vfrag_pkg::REG_ANGLE_STEP:
                    cfg_next.angle_step_max = wr_data[vfrag_pkg::INCR_W-1:0];
                vfrag_pkg::REG_SPEED_DIVISOR:
                    cfg_next.full_speed_divisor = wr_data[vfrag_pkg::SPEED_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volts_per_hz       <= vfrag_pkg::VOLTS_PER_HZ_RST;
            cfg_reg.ramp_step          <= vfrag_pkg::RAMP_STEP_RST;
            cfg_reg.angle_step_max     <= vfrag_pkg::ANGLE_STEP_RST;
            cfg_reg.full_speed_divisor <= vfrag_pkg::SPEED_DIVISOR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/vfrag_dp.sv
// datapath: ramp, v/f voltage, serial divider for the angle step, angle accumulator
// depends on vfrag_pkg; driven by vfrag_ctrl commands
`timescale 1ns / 1ps

module vfrag_dp #(
    parameter int unsigned ANGLE_FULL_SCALE = vfrag_pkg::ANGLE_FULL_SCALE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  vfrag_pkg::cfg_t                    cfg,
    input  vfrag_pkg::cmd_t                    cmd,
    input  logic [vfrag_pkg::SPEED_W-1:0]      speed_req,
    output vfrag_pkg::status_t                 st,
    output logic [vfrag_pkg::OUT_W-1:0]        out_data
);

    localparam int     ACC_W     = $clog2(ANGLE_FULL_SCALE + 1);
    localparam int     SUM_W     = $clog2(ANGLE_FULL_SCALE + 65536);
    localparam int     EXT_W     = (ACC_W > vfrag_pkg::ANGLE_W) ? ACC_W : vfrag_pkg::ANGLE_W;
    localparam int     MOD_SH    = vfrag_pkg::mod_shift(longint'(ANGLE_FULL_SCALE));
    localparam longint MOD_START = longint'(ANGLE_FULL_SCALE) << MOD_SH;

    localparam int SW = vfrag_pkg::SPEED_W;
    localparam int IW = vfrag_pkg::INCR_W;
    localparam int PW = vfrag_pkg::PROD_W;
    localparam int VW = vfrag_pkg::VOLT_W;
    localparam int CW = vfrag_pkg::CNT_W;
    localparam int VP_W = vfrag_pkg::VPH_W + SW;

    // architectural state
    logic [SW-1:0]    target_reg, target_next;
    logic [VW-1:0]    volt_reg, volt_next;
    logic [IW-1:0]    incr_reg, incr_next;
    logic [ACC_W-1:0] acc_reg, acc_next;

    // working registers
    logic [SW-1:0]             ref_reg;
    logic [PW-1:0]             prod_reg;
    logic [IW-1:0]             rem_reg;
    logic [IW-1:0]             quot_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [SUM_W-1:0]          res_reg;
    logic [SUM_W-1:0]          mod_reg;
    logic [CW-1:0]             cnt_reg;
    logic [vfrag_pkg::OUT_W-1:0] out_reg;

    logic [VP_W-1:0]  volt_prod;
    logic [VW-1:0]    volt_sat;
    logic [SW-1:0]    gap;
    logic [SW-1:0]    ramp_ext;
    logic [SW-1:0]    target_ramped;
    logic [PW-1:0]    mul_prod;
    logic [IW:0]      div_shift;
    logic [IW:0]      div_den;
    logic [IW:0]      div_diff;
    logic             div_ge;
    logic [IW-1:0]    rem_step;
    logic [IW-1:0]    quot_step;
    logic             res_ge;
    logic [SUM_W-1:0] res_step;
    logic [EXT_W-1:0] acc_ext;

    // v/f voltage from the held target
    assign volt_prod = VP_W'(cfg.volts_per_hz) * VP_W'(target_reg);
    assign volt_sat  = (volt_prod >= VP_W'(vfrag_pkg::VOLT_LIMIT))
                       ? vfrag_pkg::VOLT_LIMIT : volt_prod[VW-1:0];

    // ramp toward reference
    assign ramp_ext = SW'(cfg.ramp_step);
    assign gap      = (ref_reg >= target_reg) ? (ref_reg - target_reg) : (target_reg - ref_reg);

    always_comb
    begin
        priority if (gap >= ramp_ext && ref_reg > target_reg)
            target_ramped = target_reg + ramp_ext;
        else if (gap >= ramp_ext && ref_reg < target_reg)
            target_ramped = target_reg - ramp_ext;
        else
            target_ramped = ref_reg;
    end

    assign mul_prod = PW'(cfg.angle_step_max) * PW'(target_reg);

    // restoring division, one quotient bit per step
    assign div_shift = {rem_reg, quot_reg[IW-1]};
    assign div_den   = {1'b0, cfg.full_speed_divisor};
    assign div_ge    = (div_shift >= div_den);
    assign div_diff  = div_shift - div_den;
    assign rem_step  = div_ge ? div_diff[IW-1:0] : div_shift[IW-1:0];
    assign quot_step = {quot_reg[IW-2:0], div_ge};

    // wrap reduction by shifted full scale
    assign res_ge   = (res_reg >= mod_reg);
    assign res_step = res_ge ? (res_reg - mod_reg) : res_reg;

    assign st.div_sat = (prod_reg >= {cfg.full_speed_divisor, IW'(0)});
    assign st.wrap    = (sum_reg > SUM_W'(ANGLE_FULL_SCALE));
    assign st.last    = (cnt_reg == CW'(0));

    always_comb
    begin
        target_next = target_reg;
        volt_next   = volt_reg;
        incr_next   = incr_reg;
        acc_next    = acc_reg;
        if (cmd.volt)
        begin
            volt_next   = volt_sat;
            target_next = target_ramped;
        end
        if (cmd.incr_sat)
            incr_next = vfrag_pkg::INCR_MAX;
        if (cmd.div_step && st.last)
            incr_next = quot_step;
        if (cmd.acc_load)
            acc_next = ACC_W'(sum_reg);
        if (cmd.mod_step && st.last)
            acc_next = ACC_W'(res_step + SUM_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            volt_reg   <= '0;
            incr_reg   <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            target_reg <= target_next;
            volt_reg   <= volt_next;
            incr_reg   <= incr_next;
            acc_reg    <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_ref)
            ref_reg <= speed_req;
        if (cmd.mul)
            prod_reg <= mul_prod;
        if (cmd.div_init)
        begin
            rem_reg  <= prod_reg[PW-1:IW];
            quot_reg <= prod_reg[IW-1:0];
            cnt_reg  <= CW'(vfrag_pkg::DIV_STEPS - 1);
        end
        if (cmd.div_step)
        begin
            rem_reg  <= rem_step;
            quot_reg <= quot_step;
            cnt_reg  <= cnt_reg - CW'(1);
        end
        if (cmd.tadd)
            sum_reg <= SUM_W'(acc_reg) + SUM_W'(incr_reg);
        if (cmd.mod_init)
        begin
            res_reg <= sum_reg - SUM_W'(1);
            mod_reg <= SUM_W'(MOD_START);
            cnt_reg <= CW'(MOD_SH);
        end
        if (cmd.mod_step)
        begin
            res_reg <= res_step;
            mod_reg <= mod_reg >> 1;
            cnt_reg <= cnt_reg - CW'(1);
        end
        if (cmd.out_load)
            out_reg <= {target_reg, volt_reg, acc_ext[vfrag_pkg::ANGLE_W-1:0]};
    end

    assign acc_ext  = EXT_W'(acc_reg);
    assign out_data = out_reg;

endmodule

### hdl/vfrag_ctrl.sv
// sequencing state machine for the v/f ramp and angle generator
// depends on vfrag_pkg; commands vfrag_dp and owns the handshakes
`timescale 1ns / 1ps

module vfrag_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_mode,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  vfrag_pkg::status_t   st,
    output vfrag_pkg::cmd_t      cmd
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_VOLT = 9'b000000010,
        S_MUL  = 9'b000000100,
        S_CHK  = 9'b000001000,
        S_DIV  = 9'b000010000,
        S_TADD = 9'b000100000,
        S_TCHK = 9'b001000000,
        S_MOD  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_ref = 1'b1;
                    state_next   = in_mode ? S_VOLT : S_TADD;
                end
            end
            S_VOLT:
            begin
                cmd.volt   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (st.div_sat)
                begin
                    cmd.incr_sat = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.last)
                    state_next = S_DONE;
            end
            S_TADD:
            begin
                cmd.tadd   = 1'b1;
                state_next = S_TCHK;
            end
            S_TCHK:
            begin
                if (st.wrap)
                begin
                    cmd.mod_init = 1'b1;
                    state_next   = S_MOD;
                end
                else
                begin
                    cmd.acc_load = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (st.last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/vf_ramp_angle_generator_unit.sv
// Open-loop volts-per-hertz drive core. A beat with tuser = 1 is a control update: the
// q-voltage is set from the held speed target, the target ramps toward the reference
// and the angle step is recomputed; tuser = 0 is a PWM tick that advances the angle.
// Every input beat gives one output beat. One item is worked on at a time; a result
// waiting in the output register does not stop the next item from being taken.
// A control item passes the voltage, multiply and check states, then the restoring
// divider that yields one quotient bit per cycle; it skips the divider when the angle
// step saturates. A tick passes the add and check states, then reduction steps when the
// angle wraps, their number being set by ANGLE_FULL_SCALE (1 at the default).
// The next item can be taken from the cycle after its predecessor's result is loaded.
// depends on vfrag_pkg, vfrag_cfg, vfrag_ctrl, vfrag_dp and the assertion macro header
`timescale 1ns / 1ps

`include "vf_ramp_angle_generator_unit_assert.svh"

module vf_ramp_angle_generator_unit #(
    parameter int unsigned ANGLE_FULL_SCALE = vfrag_pkg::ANGLE_FULL_SCALE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [vfrag_pkg::SPEED_W-1:0]       s_tdata,   // requested speed
    input  logic [0:0]                          s_tuser,   // mode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [vfrag_pkg::OUT_W-1:0]         m_tdata,   // angle, voltage_q, ramp speed
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vfrag_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vfrag_pkg::CFG_DAT_W-1:0]     cfg_data
);

    vfrag_pkg::cfg_t    cfg;
    vfrag_pkg::cmd_t    cmd;
    vfrag_pkg::status_t st;

    assign cfg_ready = 1'b1;

    vfrag_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    vfrag_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_mode   (s_tuser[0]),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .st        (st),
        .cmd       (cmd)
    );

    vfrag_dp #(
        .ANGLE_FULL_SCALE (ANGLE_FULL_SCALE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .speed_req (s_tdata),
        .st        (st),
        .out_data  (m_tdata)
    );

    // one item in work at a time
    `VFRAG_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // voltage never beyond its limit
    `VFRAG_ASSERT_SAME(a_volt_limit, clk, rst_n, m_tvalid, m_tdata[31:17] <= vfrag_pkg::VOLT_LIMIT)
    // a fresh result only comes out of the busy sequence
    `VFRAG_ASSERT_SAME(a_result_from_busy, clk, rst_n, $rose(m_tvalid), $past(!s_tready))

endmodule
